/* src/wws_pkg.sv */
package wws_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned DaysPerWeek = 7;

    typedef enum logic [1:0] {
        CFG_WEEKDAY_MASK = 2'd0,
        CFG_WINDOW_START = 2'd1,
        CFG_WINDOW_STOP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [16:0] second_of_day;
    } t_in_item;

    typedef struct packed {
        logic        window_open;
        logic [19:0] seconds_to_mark;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  weekday_mask;
        logic [16:0] window_start;
        logic [16:0] window_stop;
    } t_cfg;

    // window after midnight adjustment and day class
    typedef struct packed {
        logic [16:0]        now;
        logic signed [18:0] start;
        logic signed [18:0] stop;
        logic [6:0]         rot_mask;
        logic               mask_empty;
        logic               day_cur;
        logic               day_prev;
        logic               day_none;
    } t_s1;

    // decision, selected mark and midnight offset
    typedef struct packed {
        logic               open;
        logic               whole_day;
        logic               past_mark;
        logic [16:0]        now;
        logic signed [18:0] mark;
        logic [19:0]        day_end;
    } t_s2;

    // bit k of the result is the mask bit of day today+k
    function automatic logic [6:0] rotate_mask(input logic [6:0] mask, input logic [2:0] today);
        logic [6:0] rot;
        logic [3:0] idx;
        rot = '0;
        for (int k = 0; k < 7; k++) begin
            idx = 4'(today) + 4'(k);
            if (idx >= 4'(DaysPerWeek)) begin
                idx = idx - 4'(DaysPerWeek);
            end
            rot[k] = mask[idx[2:0]];
        end
        return rot;
    endfunction

    // seconds from midnight of today to midnight (cnt + 1) days ahead; cnt of five or more gives six days
    function automatic logic [19:0] day_end_secs(input logic [2:0] cnt);
        logic [19:0] secs;
        unique case (cnt)
            3'd0:    secs = 20'(1 * SecsPerDay);
            3'd1:    secs = 20'(2 * SecsPerDay);
            3'd2:    secs = 20'(3 * SecsPerDay);
            3'd3:    secs = 20'(4 * SecsPerDay);
            3'd4:    secs = 20'(5 * SecsPerDay);
            default: secs = 20'(6 * SecsPerDay);
        endcase
        return secs;
    endfunction

endpackage

/* src/wws_cfg.sv */
module wws_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data,
    output wws_pkg::t_cfg       o_cfg
);

    wws_pkg::t_cfg r_cfg;
    wws_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (wws_pkg::t_cfg_idx'(i_cfg_index))
                wws_pkg::CFG_WEEKDAY_MASK: n_cfg.weekday_mask = i_cfg_data[6:0];
                wws_pkg::CFG_WINDOW_START: n_cfg.window_start = i_cfg_data;
                wws_pkg::CFG_WINDOW_STOP:  n_cfg.window_stop  = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weekday_mask <= 7'h7f;
            r_cfg.window_start <= '0;
            r_cfg.window_stop  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

/* src/wws_adjust.sv */
module wws_adjust (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wws_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  wws_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output wws_pkg::t_s1        o_data
);

    logic         r_valid;
    wws_pkg::t_s1 r_data;
    wws_pkg::t_s1 n_data;
    logic [2:0]   today;
    logic signed [18:0] start_ext;
    logic signed [18:0] stop_ext;
    logic signed [18:0] now_ext;
    logic         cur_set;
    logic         prev_set;

    always_comb begin
        today     = (i_data.weekday == 3'd7) ? 3'd0 : i_data.weekday;
        start_ext = signed'({2'b00, i_cfg.window_start});
        stop_ext  = signed'({2'b00, i_cfg.window_stop});
        now_ext   = signed'({2'b00, i_data.second_of_day});

        n_data.now      = i_data.second_of_day;
        n_data.start    = start_ext;
        n_data.stop     = stop_ext;
        // move one end by a day when the window crosses midnight
        if (start_ext > stop_ext) begin
            if (now_ext < stop_ext) begin
                n_data.start = start_ext - 19'(wws_pkg::SecsPerDay);
            end else begin
                n_data.stop = stop_ext + 19'(wws_pkg::SecsPerDay);
            end
        end

        n_data.rot_mask   = wws_pkg::rotate_mask(i_cfg.weekday_mask, today);
        n_data.mask_empty = (i_cfg.weekday_mask == 7'd0);
        cur_set           = n_data.rot_mask[0];
        prev_set          = n_data.rot_mask[6];
        n_data.day_cur    = cur_set || n_data.mask_empty;
        n_data.day_prev   = prev_set || n_data.mask_empty;
        n_data.day_none   = !cur_set && !prev_set && !n_data.mask_empty;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/wws_decide.sv */
module wws_decide (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wws_pkg::t_s1        i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output wws_pkg::t_s2        o_data
);

    logic         r_valid;
    wws_pkg::t_s2 r_data;
    wws_pkg::t_s2 n_data;
    logic signed [18:0] now_ext;
    logic         whole;
    logic         in_win;
    logic         open;
    logic         want;
    logic [2:0]   cnt;

    always_comb begin
        now_ext = signed'({2'b00, i_data.now});
        whole   = (i_data.start == i_data.stop);
        in_win  = (i_data.start <= now_ext) && (now_ext < i_data.stop);
        open    = !i_data.day_none &&
                  ((i_data.day_cur && whole) ||
                   (in_win && ((i_data.day_prev && i_data.start < 0) ||
                               (i_data.day_cur && i_data.start >= 0))));
        want    = !open;

        // first following day whose bit matches; default to day six
        cnt = 3'd5;
        for (int k = 6; k >= 1; k--) begin
            if (i_data.rot_mask[k] == want) begin
                cnt = 3'(k - 1);
            end
        end

        n_data.open      = open;
        n_data.whole_day = whole;
        n_data.now       = i_data.now;
        n_data.mark      = open ? i_data.stop : i_data.start;
        n_data.past_mark = now_ext > n_data.mark;
        // empty mask: zero seconds to the next midnight
        n_data.day_end   = i_data.mask_empty ? 20'(i_data.now)
                                             : wws_pkg::day_end_secs(cnt);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/wws_count.sv */
module wws_count (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wws_pkg::t_s2        i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output wws_pkg::t_out_item  o_data
);

    logic               r_valid;
    wws_pkg::t_out_item r_data;
    wws_pkg::t_out_item n_data;
    logic signed [21:0] now_ext;
    logic signed [21:0] mark_ext;
    logic signed [21:0] end_ext;
    logic signed [21:0] secs;

    always_comb begin
        now_ext  = signed'({5'd0, i_data.now});
        mark_ext = 22'(i_data.mark);
        end_ext  = signed'({2'b00, i_data.day_end});

        priority if (i_data.whole_day) begin
            secs = end_ext - now_ext;
        end else if (i_data.past_mark) begin
            secs = end_ext - now_ext + mark_ext;
        end else begin
            secs = mark_ext - now_ext;
        end

        n_data.window_open = i_data.open;
        // clamp to the field range
        priority if (secs < 0) begin
            n_data.seconds_to_mark = 20'd0;
        end else if (secs > 22'sd1048575) begin
            n_data.seconds_to_mark = 20'hfffff;
        end else begin
            n_data.seconds_to_mark = secs[19:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/weekly_window_scheduler.sv */
// Each item passes the registered adjust, decide and count stages in that order before its
// result is offered at the output.
// Throughput: one item per cycle; each stage holds while its successor is full and stalled.
// Reset (synchronous, active low) empties all stages and loads weekday mask 127,
// window start 0 and window stop 0.
module weekly_window_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wws_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wws_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data
);

    wws_pkg::t_cfg cfg;
    wws_pkg::t_s1  s1_data;
    wws_pkg::t_s2  s2_data;
    logic          s1_valid;
    logic          s1_ready;
    logic          s2_valid;
    logic          s2_ready;

    wws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wws_adjust u_adjust (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    wws_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    wws_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

/* tb/sv/weekly_window_scheduler_tb.sv */
`timescale 1ns / 100ps

module weekly_window_scheduler_tb;

    localparam longint DaySecs     = longint'(wws_pkg::SecsPerDay);
    localparam int     WeekDays    = int'(wws_pkg::DaysPerWeek);
    localparam longint MarkMax     = 64'hFFFFF;
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     STALL_CYCLES = 150;
    localparam int     RANDOM_BATCHES = 12;
    localparam int     BATCH_ITEMS = 58;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    wws_pkg::t_in_item   i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    wws_pkg::t_out_item  o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = wws_pkg::CFG_WEEKDAY_MASK;
    logic [16:0]         i_cfg_data = '0;

    wws_pkg::t_in_item  pending_queries[$];
    wws_pkg::t_out_item expected_answers[$];
    wws_pkg::t_cfg      sched_cfg = '{weekday_mask: 7'h7F, window_start: '0, window_stop: '0};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int stall_left = 0;
    int mismatches = 0;
    int answers_checked = 0;
    int cycles = 0;

    weekly_window_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint secs_to_matching_midnight(input logic [6:0] mask,
                                                         input int today,
                                                         input longint now,
                                                         input logic want);
        longint count;
        logic   found;
        count = 5;
        found = 1'b0;
        if (mask == '0) begin
            return 0;
        end
        for (int k = 1; k < WeekDays; k++) begin
            if (!found && mask[(today + k) % WeekDays] == want) begin
                count = k - 1;
                found = 1'b1;
            end
        end
        return DaySecs - now + count * DaySecs;
    endfunction

    function automatic wws_pkg::t_out_item predict_schedule(input wws_pkg::t_cfg c,
                                                           input wws_pkg::t_in_item q);
        int                 today;
        int                 yday;
        longint             now;
        longint             start;
        longint             stop;
        longint             mark;
        longint             secs;
        logic               mask_empty;
        logic               counts_today;
        logic               counts_yday;
        logic               open_now;
        wws_pkg::t_out_item res;
        today = int'(q.weekday) % WeekDays;
        yday = (today + WeekDays - 1) % WeekDays;
        now = longint'(q.second_of_day);
        start = longint'(c.window_start);
        stop = longint'(c.window_stop);
        if (start > stop) begin
            if (now < stop) begin
                start = start - DaySecs;
            end else begin
                stop = stop + DaySecs;
            end
        end
        mask_empty = (c.weekday_mask == '0);
        counts_today = c.weekday_mask[today] || mask_empty;
        counts_yday = c.weekday_mask[yday] || mask_empty;
        open_now = 1'b0;
        if (counts_today || counts_yday) begin
            if (counts_today && start == stop) begin
                open_now = 1'b1;
            end else if (start <= now && now < stop) begin
                if (counts_yday && start < 0) begin
                    open_now = 1'b1;
                end else if (counts_today && start >= 0) begin
                    open_now = 1'b1;
                end
            end
        end
        if (start == stop) begin
            secs = secs_to_matching_midnight(c.weekday_mask, today, now, !open_now);
        end else begin
            mark = open_now ? stop : start;
            if (now > mark) begin
                secs = secs_to_matching_midnight(c.weekday_mask, today, now, !open_now) + mark;
            end else begin
                secs = mark - now;
            end
        end
        if (secs < 0) begin
            secs = 0;
        end
        if (secs > MarkMax) begin
            secs = MarkMax;
        end
        res.window_open = open_now;
        res.seconds_to_mark = 20'(secs);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 what, answers_checked, got, want);
    endtask

    // drive queries
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_queries.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_answers.push_back(predict_schedule(sched_cfg, i_in_data));
        end
    end

    // hold off the result side on request, else stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stalls_served != stall_requests) begin
            stalls_served <= stall_requests;
            stall_left <= STALL_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        wws_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", longint'(o_out_data.seconds_to_mark), 0);
            end else begin
                want = expected_answers.pop_front();
                if (o_out_data.window_open !== want.window_open) begin
                    report_mismatch("window_open", longint'(o_out_data.window_open),
                                    longint'(want.window_open));
                end
                if (o_out_data.seconds_to_mark !== want.seconds_to_mark) begin
                    report_mismatch("seconds_to_mark", longint'(o_out_data.seconds_to_mark),
                                    longint'(want.seconds_to_mark));
                end
            end
            answers_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained;
        do @(posedge i_clk);
        while (pending_queries.size() != 0 || i_in_valid || expected_answers.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            wws_pkg::CFG_WEEKDAY_MASK: sched_cfg.weekday_mask = value[6:0];
            wws_pkg::CFG_WINDOW_START: sched_cfg.window_start = value;
            wws_pkg::CFG_WINDOW_STOP:  sched_cfg.window_stop = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_schedule(input logic [6:0] mask, input logic [16:0] start,
                                 input logic [16:0] stop);
        write_reg(wws_pkg::CFG_WEEKDAY_MASK, 17'(mask));
        write_reg(wws_pkg::CFG_WINDOW_START, start);
        write_reg(wws_pkg::CFG_WINDOW_STOP, stop);
    endtask

    task automatic add_query(input int wd, input int sod);
        wws_pkg::t_in_item q;
        q.weekday = 3'(wd);
        q.second_of_day = 17'(sod);
        pending_queries.push_back(q);
    endtask

    function automatic logic [16:0] pick_time();
        case ($urandom_range(9))
            0:       return 17'd0;
            1:       return 17'd86399;
            2:       return 17'($urandom_range(131071));
            default: return 17'($urandom_range(86399));
        endcase
    endfunction

    function automatic int pick_second();
        longint base;
        case ($urandom_range(9))
            0: return $urandom_range(131071);
            1: return $urandom_range(1) ? 0 : 86399;
            2, 3: begin
                base = $urandom_range(1) ? longint'(sched_cfg.window_start)
                                         : longint'(sched_cfg.window_stop);
                base = base + longint'($urandom_range(2)) - 1;
                if (base < 0) begin
                    base = 0;
                end
                if (base > 131071) begin
                    base = 131071;
                end
                return int'(base);
            end
            default: return $urandom_range(86399);
        endcase
    endfunction

    initial begin
        logic [6:0]  mask;
        logic [16:0] start;
        logic [16:0] stop;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whole day, every day
        add_query(0, 0);
        add_query(1, 86399);
        add_query(2, 131071);
        add_query(6, 43200);
        add_query(7, 100);
        add_query(7, 86399);
        wait_drained();

        // empty mask, window across midnight
        load_schedule(7'h00, 17'd79200, 17'd7200);
        add_query(2, 3600);
        add_query(2, 7200);
        add_query(2, 79200);
        add_query(5, 50000);
        wait_drained();

        // Monday only, daytime window
        load_schedule(7'b000_0001, 17'd28800, 17'd61200);
        add_query(0, 28799);
        add_query(0, 28800);
        add_query(0, 61199);
        add_query(0, 61200);
        add_query(3, 30000);
        add_query(6, 30000);
        wait_drained();

        // Monday only, across midnight: previous-day and current-day cases
        load_schedule(7'b000_0001, 17'd72000, 17'd3600);
        add_query(1, 1000);
        add_query(0, 1000);
        add_query(0, 80000);
        add_query(6, 80000);
        wait_drained();

        // unused index, then times beyond one day
        write_reg(CFG_SPARE_IDX, 17'h1FFFF);
        load_schedule(7'h7F, 17'h1FFFF, 17'd100000);
        add_query(4, 131071);
        add_query(4, 99999);
        add_query(4, 110000);
        wait_drained();

        for (int b = 0; b < RANDOM_BATCHES; b++) begin
            if (b < RANDOM_BATCHES / 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 55;
            end else if (b < 2 * RANDOM_BATCHES / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(7))
                0:       mask = 7'h00;
                1:       mask = 7'h7F;
                2:       mask = 7'(1 << $urandom_range(6));
                default: mask = 7'($urandom_range(127));
            endcase
            start = pick_time();
            stop = ($urandom_range(5) == 0) ? start : pick_time();
            load_schedule(mask, start, stop);
            if (b == RANDOM_BATCHES - 2) begin
                stall_requests++;
            end
            for (int n = 0; n < BATCH_ITEMS; n++) begin
                add_query($urandom_range(7), pick_second());
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/wws_pkg.sv
src/wws_cfg.sv
src/wws_adjust.sv
src/wws_decide.sv
src/wws_count.sv
src/weekly_window_scheduler.sv
tb/sv/weekly_window_scheduler_tb.sv
